/* rtl/core/mbps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int unsigned PatternW = 64;
  localparam int unsigned CareW    = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned RegionW  = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN = 8'd0,
    CFG_CARE    = 8'd1,
    CFG_LENGTH  = 8'd2,
    CFG_REGION  = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [CareW-1:0]    care;
    logic [LenW-1:0]     length;
    logic [RegionW-1:0]  region;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/masked_byte_pattern_scan_unit.sv */
// Masked byte pattern scanner.
// Input queue: drive data_byte_i with push; a byte is taken on a clock edge
// with push high and full low. Bytes of a region arrive in address order.
// Result queue: while empty is low, found_o and match_offset_o show the
// oldest result; pop on a clock edge with empty low removes it.
// Each region of region_size bytes yields exactly one result: the first
// matching start offset (found_o = 1) as soon as its last byte is taken, or
// not found (found_o = 0, offset 0) with the final byte. Bytes after a match
// are absorbed without result; the block rearms after the final byte.
// Config port: cfg_index_i selects pattern, care mask, length or region size;
// cfg_ready_o is always high, write only while the scanner is idle.
// Throughput is one byte per cycle while full is low; the window compare is
// combinational. A result passes through the result queue and then the
// output register before empty goes low and it can be popped.
// A two-entry result queue plus the output register absorb a stalled
// receiver; once both are full, full goes high and input stalls.
// Reset clears the window, the byte count and both queues, and loads the
// register defaults (length 1, region 1, all bytes cared).
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scan_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mbps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [mbps_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      data_byte_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 found_o,
  output logic [31:0]                          match_offset_o
);

  localparam int unsigned OffW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

  mbps_pkg::cfg_t cfg_q;

  logic            accept;
  logic            res_valid, res_found;
  logic [OffW-1:0] res_offset;
  logic [OffW:0]   q_rd_data;
  logic            q_empty, q_rd;
  logic [OffW-1:0] out_offset;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.care    <= '1;
      cfg_q.length  <= mbps_pkg::LenW'(1);
      cfg_q.region  <= mbps_pkg::RegionW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mbps_pkg::CFG_PATTERN: cfg_q.pattern <= cfg_data_i;
        mbps_pkg::CFG_CARE:    cfg_q.care    <= cfg_data_i[mbps_pkg::CareW-1:0];
        mbps_pkg::CFG_LENGTH:  cfg_q.length  <= cfg_data_i[mbps_pkg::LenW-1:0];
        mbps_pkg::CFG_REGION:  cfg_q.region  <= cfg_data_i[mbps_pkg::RegionW-1:0];
        default: ;
      endcase
    end
  end

  mbps_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .OFF_W            (OffW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_found_o (res_found),
    .res_offset_o(res_offset)
  );

  mbps_fifo #(
    .DATA_W(OffW + 1),
    .DEPTH (2)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (res_valid),
    .wr_data_i({res_found, res_offset}),
    .rd_i     (q_rd),
    .rd_data_o(q_rd_data),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  mbps_back #(
    .OFF_W(OffW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_found_i (q_rd_data[OffW]),
    .q_offset_i(q_rd_data[OffW-1:0]),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .found_o   (found_o),
    .offset_o  (out_offset)
  );

  assign match_offset_o = 32'(out_offset);

endmodule

`default_nettype wire

/* rtl/core/mbps_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbps_front #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFF_W             = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mbps_pkg::cfg_t     cfg_i,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    res_valid_o,
  output logic                    res_found_o,
  output logic [OFF_W-1:0]        res_offset_o
);

  localparam int unsigned IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [MAX_PATTERN_BYTES-1:0][7:0] win_q, win_d, win_shift;
  logic [mbps_pkg::CountW-1:0]       seen_q, seen_d;
  logic                              reported_q, reported_d;

  logic [mbps_pkg::LenW-1:0]         len;
  logic [mbps_pkg::RegionW-1:0]      size;
  logic [mbps_pkg::CountW-1:0]       n;
  logic [mbps_pkg::CountW-1:0]       start;
  logic                              miss, hit, last;
  logic [mbps_pkg::LenW-1:0]         back;

  always_comb begin
    win_shift[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_shift[j] = win_q[j-1];
    end
  end

  // clamp length to 1..MAX, region size zero acts as one
  always_comb begin
    if (cfg_i.length == '0) begin
      len = mbps_pkg::LenW'(1);
    end else if (cfg_i.length > mbps_pkg::LenW'(MAX_PATTERN_BYTES)) begin
      len = mbps_pkg::LenW'(MAX_PATTERN_BYTES);
    end else begin
      len = cfg_i.length;
    end
    size = (cfg_i.region == '0) ? mbps_pkg::RegionW'(1) : cfg_i.region;
  end

  // pattern byte k lines up with the byte len-1-k positions back
  always_comb begin
    miss = 1'b0;
    back = '0;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      back = len - mbps_pkg::LenW'(1) - mbps_pkg::LenW'(k);
      if ((mbps_pkg::LenW'(k) < len) && cfg_i.care[k] &&
          (win_shift[back[IdxW-1:0]] != cfg_i.pattern[8*k +: 8])) begin
        miss = 1'b1;
      end
    end
  end

  always_comb begin
    n     = seen_q + mbps_pkg::CountW'(1);
    start = n - mbps_pkg::CountW'(len);
    hit   = !reported_q && (n >= mbps_pkg::CountW'(len)) && (n <= size) && !miss;
    last  = (n >= size);

    res_valid_o  = accept_i && (hit || (last && !reported_q));
    res_found_o  = hit;
    res_offset_o = hit ? start[OFF_W-1:0] : '0;

    win_d      = win_q;
    seen_d     = seen_q;
    reported_d = reported_q;
    if (accept_i) begin
      if (last) begin
        // rearm for the next region
        win_d      = '0;
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        win_d      = win_shift;
        seen_d     = n;
        reported_d = reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      win_q      <= win_d;
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbps_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbps_fifo #(
  parameter int unsigned DATA_W = 33,
  parameter int unsigned DEPTH  = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_i,
  output logic [DATA_W-1:0]      rd_data_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbps_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbps_back #(
  parameter int unsigned OFF_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire logic             q_found_i,
  input  wire logic [OFF_W-1:0] q_offset_i,
  output logic                  q_rd_o,
  input  wire logic             pop,
  output logic                  empty,
  output logic                  found_o,
  output logic [OFF_W-1:0]      offset_o
);

  logic             valid_q, valid_d;
  logic             found_q;
  logic [OFF_W-1:0] offset_q;
  logic             load;

  // refill the output register when it drains or sits empty
  assign load    = !q_empty_i && (!valid_q || pop);
  assign q_rd_o  = load;
  assign empty   = !valid_q;
  assign found_o  = found_q;
  assign offset_o = offset_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q  <= q_found_i;
      offset_q <= q_offset_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbps_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        found_o,
  input wire logic [31:0] match_offset_o
);

  // hold a waiting result until it is popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(found_o) && $stable(match_offset_o)))
    else $error("result changed while waiting");

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (match_offset_o == 32'd0))
    else $error("not-found result with nonzero offset");

  a_full_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted request");

endmodule

bind masked_byte_pattern_scan_unit mbps_checker u_mbps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .found_o       (found_o),
  .match_offset_o(match_offset_o)
);

`default_nettype wire
